>>> rtl/pcicfg_pkg.sv
// Shared types and constants for the PCI configuration mechanism one host.
package pcicfg_pkg;

  localparam logic [1:0] OP_PORT_RD = 2'd0;
  localparam logic [1:0] OP_PORT_WR = 2'd1;
  localparam logic [1:0] OP_REG_DEV = 2'd2;
  localparam logic [1:0] OP_LOAD    = 2'd3;

  localparam logic [12:0] PORT_BASE_HI = 13'h19F;  // 0xCF8 >> 3
  localparam logic [7:0]  PROT_LAST    = 8'd6;

  typedef struct packed {
    logic [1:0] op;
    logic [15:0] port;
    logic [7:0] data_byte;
    logic [7:0] hw_device;
    logic [2:0] function_num;
    logic [7:0] size_dwords;
    logic       has_handler;
    logic [3:0] load_slot;
    logic [7:0] load_offset;
  } req_t;

  typedef struct packed {
    logic       handled;
    logic [7:0] read_data;
    logic       change_valid;
    logic [7:0] change_offset;
    logic [7:0] change_device;
    logic [2:0] change_function;
    logic       reg_ok;
    logic [3:0] reg_slot;
  } rsp_t;

  typedef struct packed {
    logic [7:0] hw;
    logic [7:0] dev;
    logic [2:0] func;
    logic [7:0] size;
    logic       notify;
  } slot_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_ACC,
    ST_MEM,
    ST_REG,
    ST_DONE
  } state_e;

endpackage

>>> rtl/pcicfg_req_if.sv
// Request channel: valid/ready handshake with a request payload.
interface pcicfg_req_if import pcicfg_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/pcicfg_rsp_if.sv
// Response channel: valid/ready handshake with a response payload.
interface pcicfg_rsp_if import pcicfg_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/pcicfg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcicfg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/pci_config_mechanism_one_host_unit.sv
// PCI configuration mechanism one host: byte ports 0xCF8..0xCFF, slot table and config memory.
// One request at a time. Requests that need no decode (foreign ports, status reads, address
// writes and data accesses that fail the enable, alignment or bus check) and back-door loads
// go from accept straight to ST_DONE and the output register. An address write or data access
// that decodes scans the slots in order, an ST_RD and an ST_CHK step per slot, until the first
// hit; a data access that hits then passes ST_ACC, and a read also ST_MEM to read the config
// memory. Registration always scans all slots, then writes the first free slot, if any, in ST_REG.
// The slot table lives in a RAM read once per scan step; valid bits are flip-flops. A finished
// response waits in an output register; the next request is taken only once it has moved there.
module pci_config_mechanism_one_host_unit
  import pcicfg_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int CFG_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcicfg_req_if.sink  req_i,
  pcicfg_rsp_if.source rsp_o
);
  localparam int SW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS * CFG_BYTES);

  state_e state_q, state_d;
  req_t req_q, req_d;
  rsp_t res_q, res_d, out_q, out_d;
  logic out_vld_q, out_vld_d;
  logic [31:0] addr_q, addr_d;
  logic status_q, status_d;
  logic [7:0] next_dev_q, next_dev_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [SW-1:0] idx_q, idx_d;
  logic found_q, found_d;
  logic [7:0] devnum_q, devnum_d;
  logic free_found_q, free_found_d;
  logic [SW-1:0] free_idx_q, free_idx_d;
  logic [SW-1:0] hit_idx_q, hit_idx_d;
  slot_rec_t hit_rec_q, hit_rec_d;

  logic slot_we;
  logic [SW-1:0] slot_waddr;
  slot_rec_t slot_wdata, slot_rdata;
  logic cfg_we;
  logic [CW-1:0] cfg_waddr, cfg_raddr, cfg_addr;
  logic [7:0] cfg_wdata, cfg_rdata;
  logic [7:0] off;
  logic [7:0] dev_num;
  logic last, hit;

  pcicfg_ram #(.Width($bits(slot_rec_t)), .Depth(NUM_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (idx_q),
    .rdata_o (slot_rdata)
  );

  pcicfg_ram #(.Width(8), .Depth(NUM_SLOTS * CFG_BYTES)) u_cfg_ram (
    .clk_i   (clk_i),
    .we_i    (cfg_we),
    .waddr_i (cfg_waddr),
    .wdata_i (cfg_wdata),
    .raddr_i (cfg_raddr),
    .rdata_o (cfg_rdata)
  );

  assign off = {addr_q[7:2], req_q.port[1:0]};
  assign cfg_addr = CW'(CW'(hit_idx_q) * CW'(CFG_BYTES) + CW'(off));
  assign cfg_raddr = cfg_addr;
  assign last = idx_q == SW'(NUM_SLOTS - 1);
  assign hit = valid_q[idx_q] && slot_rdata.dev == {3'b000, addr_q[15:11]} &&
               slot_rdata.func == addr_q[10:8] && {2'b00, addr_q[7:2]} < slot_rdata.size;
  assign dev_num = found_q ? devnum_q : next_dev_q;

  assign req_i.ready = state_q == ST_IDLE;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.payload = out_q;

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    res_d = res_q;
    out_d = out_q;
    out_vld_d = out_vld_q;
    addr_d = addr_q;
    status_d = status_q;
    next_dev_d = next_dev_q;
    valid_d = valid_q;
    idx_d = idx_q;
    found_d = found_q;
    devnum_d = devnum_q;
    free_found_d = free_found_q;
    free_idx_d = free_idx_q;
    hit_idx_d = hit_idx_q;
    hit_rec_d = hit_rec_q;
    slot_we = 1'b0;
    slot_waddr = free_idx_q;
    slot_wdata = '{hw: req_q.hw_device, dev: dev_num, func: req_q.function_num,
                   size: req_q.size_dwords, notify: req_q.has_handler};
    cfg_we = 1'b0;
    cfg_waddr = cfg_addr;
    cfg_wdata = req_q.data_byte;
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          req_d = req_i.payload;
          res_d = '0;
          idx_d = '0;
          found_d = 1'b0;
          free_found_d = 1'b0;
          state_d = ST_DONE;
          case (req_i.payload.op)
            OP_PORT_RD, OP_PORT_WR: begin
              if (req_i.payload.port[15:3] != PORT_BASE_HI) begin
                state_d = ST_DONE;
              end else if (!req_i.payload.port[2]) begin
                res_d.handled = 1'b1;
                if (req_i.payload.op == OP_PORT_RD) begin
                  if (!status_q) begin
                    res_d.read_data = 8'hFF;
                  end else if (req_i.payload.port[1:0] == 2'd3) begin
                    res_d.read_data = 8'h80;
                  end
                end else begin
                  addr_d[{req_i.payload.port[1:0], 3'b000} +: 8] = req_i.payload.data_byte;
                  status_d = 1'b0;
                  if (addr_d[31] && addr_d[1:0] == 2'b00 && addr_d[23:16] == 8'h00) begin
                    state_d = ST_RD;
                  end
                end
              end else if (addr_q[31]) begin
                res_d.handled = 1'b1;
                if (req_i.payload.op == OP_PORT_RD) begin
                  res_d.read_data = 8'hFF;
                end
                status_d = 1'b0;
                if (addr_q[1:0] == 2'b00 && addr_q[23:16] == 8'h00) begin
                  state_d = ST_RD;
                end
              end
            end
            OP_REG_DEV: begin
              state_d = ST_RD;
            end
            default: begin
              if (32'(req_i.payload.load_slot) < NUM_SLOTS &&
                  32'(req_i.payload.load_offset) < CFG_BYTES) begin
                cfg_we = 1'b1;
                cfg_waddr = CW'(CW'(req_i.payload.load_slot) * CW'(CFG_BYTES) +
                                CW'(req_i.payload.load_offset));
                cfg_wdata = req_i.payload.data_byte;
              end
            end
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (req_q.op == OP_REG_DEV) begin
          if (valid_q[idx_q] && slot_rdata.hw == req_q.hw_device) begin
            found_d = 1'b1;
            devnum_d = slot_rdata.dev;
          end
          if (!valid_q[idx_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d = idx_q;
          end
          if (last) begin
            state_d = ST_REG;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = ST_RD;
          end
        end else if (hit) begin
          status_d = 1'b1;
          hit_idx_d = idx_q;
          hit_rec_d = slot_rdata;
          state_d = req_q.port[2] ? ST_ACC : ST_DONE;
        end else if (last) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = ST_RD;
        end
      end
      ST_ACC: begin
        state_d = ST_DONE;
        if (req_q.op == OP_PORT_RD) begin
          if (32'(off) < CFG_BYTES) begin
            state_d = ST_MEM;
          end
        end else if (off > PROT_LAST && 32'(off) < CFG_BYTES) begin
          cfg_we = 1'b1;
          if (hit_rec_q.notify) begin
            res_d.change_valid = 1'b1;
            res_d.change_offset = off;
            res_d.change_device = hit_rec_q.hw;
            res_d.change_function = hit_rec_q.func;
          end
        end
      end
      ST_MEM: begin
        res_d.read_data = cfg_rdata;
        state_d = ST_DONE;
      end
      ST_REG: begin
        if (!found_q) begin
          next_dev_d = next_dev_q + 8'd1;
        end
        if (free_found_q) begin
          slot_we = 1'b1;
          valid_d[free_idx_q] = 1'b1;
          res_d.reg_ok = 1'b1;
          res_d.reg_slot = 4'(free_idx_q);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d = res_q;
          out_vld_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_vld_q <= 1'b0;
      addr_q <= '0;
      status_q <= 1'b0;
      next_dev_q <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      out_vld_q <= out_vld_d;
      addr_q <= addr_d;
      status_q <= status_d;
      next_dev_q <= next_dev_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
    idx_q <= idx_d;
    found_q <= found_d;
    devnum_q <= devnum_d;
    free_found_q <= free_found_d;
    free_idx_q <= free_idx_d;
    hit_idx_q <= hit_idx_d;
    hit_rec_q <= hit_rec_d;
  end
endmodule

>>> dv/tb.sv
// Testbench for the PCI config mechanism one host: directed and random requests checked against a local model.
`timescale 1ns / 100ps

module tb;
  import pcicfg_pkg::*;

  localparam int NSLOT     = 16;
  localparam int CFGB      = 256;
  localparam int WD_LIMIT  = 2000;
  localparam int LONG_HOLD = 300;
  localparam int P_ADDR    = 'hCF8;
  localparam int P_DATA    = 'hCFC;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pcicfg_req_if req_if ();
  pcicfg_rsp_if rsp_if ();

  pci_config_mechanism_one_host_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #6 clk = ~clk;

  // host model state
  logic [31:0] addr_q;
  bit          stat_ok;
  logic [7:0]  next_dev;
  bit          s_vld[NSLOT];
  logic [7:0]  s_hw[NSLOT];
  logic [7:0]  s_dev[NSLOT];
  logic [2:0]  s_fn[NSLOT];
  logic [7:0]  s_sz[NSLOT];
  bit          s_ntf[NSLOT];
  logic [7:0]  cfg_mem[NSLOT*CFGB];
  bit          cfg_set[NSLOT*CFGB];

  rsp_t exp_q[$];
  int   errors = 0;
  int   n_req = 0;
  int   n_rsp = 0;
  int   n_chg = 0;
  int   n_regok = 0;
  bit   no_idle = 1'b0;
  bit   long_hold = 1'b0;
  int   idle_cyc = 0;

  function automatic bit slot_hit(input logic [31:0] a, output int slot, output int base);
    slot = 0;
    base = 0;
    if (!a[31] || a[1:0] != 2'b00 || a[23:16] != 8'h00) return 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (s_vld[i] && s_dev[i] == {3'b000, a[15:11]} && s_fn[i] == a[10:8] &&
          {2'b00, a[7:2]} < s_sz[i]) begin
        slot = i;
        base = int'({a[7:2], 2'b00});
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t host_step(input req_t r);
    rsp_t o;
    int slot, base, off, dn;
    bit hit, found, placed;
    logic [31:0] st;
    o = '0;
    case (r.op)
      OP_PORT_RD, OP_PORT_WR: begin
        if (r.port[15:3] == PORT_BASE_HI) begin
          if (!r.port[2]) begin
            o.handled = 1'b1;
            if (r.op == OP_PORT_RD) begin
              st = stat_ok ? 32'h8000_0000 : 32'hFFFF_FFFF;
              o.read_data = st[8*r.port[1:0] +: 8];
            end else begin
              addr_q[8*r.port[1:0] +: 8] = r.data_byte;
              stat_ok = slot_hit(addr_q, slot, base);
            end
          end else if (addr_q[31]) begin
            o.handled = 1'b1;
            hit = slot_hit(addr_q, slot, base);
            stat_ok = hit;
            off = base | r.port[1:0];
            if (r.op == OP_PORT_RD) begin
              o.read_data = 8'hFF;
              if (hit && off < CFGB) o.read_data = cfg_mem[slot*CFGB + off];
            end else if (hit && off > PROT_LAST && off < CFGB) begin
              cfg_mem[slot*CFGB + off] = r.data_byte;
              cfg_set[slot*CFGB + off] = 1'b1;
              if (s_ntf[slot]) begin
                o.change_valid    = 1'b1;
                o.change_offset   = off[7:0];
                o.change_device   = s_hw[slot];
                o.change_function = s_fn[slot];
              end
            end
          end
        end
      end
      OP_REG_DEV: begin
        found = 1'b0;
        placed = 1'b0;
        dn = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (s_vld[i] && s_hw[i] == r.hw_device) begin
            dn = int'(s_dev[i]);
            found = 1'b1;
          end
        end
        if (!found) begin
          dn = int'(next_dev);
          next_dev = next_dev + 8'd1;
        end
        for (int i = 0; i < NSLOT; i++) begin
          if (!placed && !s_vld[i]) begin
            placed = 1'b1;
            s_vld[i] = 1'b1;
            s_sz[i] = r.size_dwords;
            s_ntf[i] = r.has_handler;
            s_hw[i] = r.hw_device;
            s_fn[i] = r.function_num;
            s_dev[i] = dn[7:0];
            o.reg_ok = 1'b1;
            o.reg_slot = i[3:0];
          end
        end
      end
      default: begin
        if (r.load_slot < NSLOT && r.load_offset < CFGB) begin
          cfg_mem[r.load_slot*CFGB + r.load_offset] = r.data_byte;
          cfg_set[r.load_slot*CFGB + r.load_offset] = 1'b1;
        end
      end
    endcase
    return o;
  endfunction

  // a data read that would land on a never-written byte; gives its index
  function automatic bit unset_read(input req_t r, output int idx);
    int slot, base;
    idx = 0;
    if (r.op != OP_PORT_RD || r.port[15:2] != P_DATA[15:2] || !addr_q[31]) return 1'b0;
    if (!slot_hit(addr_q, slot, base)) return 1'b0;
    idx = slot*CFGB + (base | r.port[1:0]);
    return !cfg_set[idx];
  endfunction

  function automatic req_t rand_req(input logic [1:0] op);
    logic [63:0] rv;
    req_t r;
    rv = {$urandom, $urandom};
    r = rv[57:0];
    r.op = op;
    return r;
  endfunction

  task automatic put_req(input req_t r);
    int w;
    w = no_idle ? 0 : $urandom_range(0, 10);
    if (w > 0) begin
      req_if.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    exp_q.push_back(host_step(r));
    n_req++;
  endtask

  task automatic send(input req_t r);
    req_t ld;
    int idx;
    if (unset_read(r, idx)) begin
      ld = rand_req(OP_LOAD);
      ld.load_slot = 4'(idx / CFGB);
      ld.load_offset = 8'(idx % CFGB);
      put_req(ld);
    end
    put_req(r);
  endtask

  task automatic port_rd(input int p);
    req_t r;
    r = rand_req(OP_PORT_RD);
    r.port = 16'(p);
    send(r);
  endtask

  task automatic port_wr(input int p, input logic [7:0] d);
    req_t r;
    r = rand_req(OP_PORT_WR);
    r.port = 16'(p);
    r.data_byte = d;
    send(r);
  endtask

  task automatic set_addr(input logic [31:0] a);
    for (int i = 0; i < 4; i++) port_wr(P_ADDR + i, a[8*i +: 8]);
  endtask

  task automatic reg_dev(input logic [7:0] hw, input logic [2:0] fn, input logic [7:0] sz,
                         input bit h);
    req_t r;
    r = rand_req(OP_REG_DEV);
    r.hw_device = hw;
    r.function_num = fn;
    r.size_dwords = sz;
    r.has_handler = h;
    send(r);
  endtask

  task automatic load_byte(input logic [3:0] s, input logic [7:0] off, input logic [7:0] d);
    req_t r;
    r = rand_req(OP_LOAD);
    r.load_slot = s;
    r.load_offset = off;
    r.data_byte = d;
    send(r);
  endtask

  function automatic logic [31:0] cfg_addr(input logic [4:0] dev, input logic [2:0] fn,
                                          input logic [5:0] rg);
    return {1'b1, 7'd0, 8'd0, dev, fn, rg, 2'b00};
  endfunction

  task automatic drain();
    req_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    port_rd('h0000);
    port_wr('hFFFF, 8'hFF);
    port_rd('h0CF7);
    port_wr('h0D00, 8'h5A);
    for (int i = 0; i < 4; i++) port_rd(P_ADDR + i);
    port_rd(P_DATA);
    port_wr('h0CFF, 8'h11);
    reg_dev(8'hAA, 3'd0, 8'd255, 1'b1);
    reg_dev(8'hAA, 3'd1, 8'd1, 1'b0);
    reg_dev(8'h55, 3'd7, 8'd0, 1'b1);
    set_addr(cfg_addr(5'd0, 3'd0, 6'd0));
    port_rd(P_ADDR + 3);
    port_wr(P_DATA, 8'hFF);
    port_rd(P_DATA + 2);
    port_wr(P_ADDR + 0, 8'h04);
    port_wr(P_DATA + 3, 8'hC3);
    port_rd(P_DATA + 3);
    port_wr(P_ADDR + 2, 8'h01);
    port_rd(P_DATA);
    port_rd(P_ADDR);
    port_wr(P_ADDR, 8'h07);
    load_byte(4'd15, 8'hFF, 8'hFF);
    load_byte(4'd0, 8'h00, 8'h00);
  endtask

  task automatic test_random(input int n);
    int k, s, c;
    logic [5:0] rg;
    for (int it = 0; it < n; it++) begin
      if (it % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      c = $urandom_range(0, 99);
      if (c < 6) begin
        reg_dev(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11)),
                3'($urandom), ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                8'($urandom_range(0, 20)), 1'($urandom));
      end else if (c < 45) begin
        s = $urandom_range(0, NSLOT - 1);
        rg = ($urandom_range(0, 3) == 0) ? 6'($urandom) :
             6'($urandom_range(0, (s_sz[s] > 0 && s_sz[s] < 64) ? s_sz[s] - 1 : 63));
        set_addr(cfg_addr(s_dev[s][4:0], s_fn[s], rg));
        k = $urandom_range(1, 4);
        repeat (k) begin
          if ($urandom_range(0, 1)) port_rd(P_DATA + $urandom_range(0, 3));
          else port_wr(P_DATA + $urandom_range(0, 3), 8'($urandom));
        end
      end else if (c < 58) begin
        load_byte(4'($urandom), 8'($urandom), 8'($urandom));
      end else if (c < 72) begin
        if ($urandom_range(0, 1)) port_rd(P_ADDR + $urandom_range(0, 3));
        else port_wr(P_ADDR + $urandom_range(0, 3), 8'($urandom));
      end else if (c < 86) begin
        if ($urandom_range(0, 1)) port_rd(($urandom_range(0, 1)) ? $urandom :
                                          $urandom_range('hCF0, 'hD07));
        else port_wr($urandom, 8'($urandom));
      end else begin
        if ($urandom_range(0, 1)) port_rd(P_DATA + $urandom_range(0, 3));
        else port_wr(P_DATA + $urandom_range(0, 3), 8'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_dev_wrap();
    for (int i = 0; i < 270; i++) reg_dev(8'(i + 8'h40), 3'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic test_backpressure();
    drain();
    long_hold = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 20; i++) port_rd(P_ADDR + i % 4);
    no_idle = 1'b0;
    drain();
  endtask

  task automatic cmp(input string f, input logic [7:0] e, input logic [7:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", f, e, a);
      errors++;
    end
  endtask

  task automatic check_rsp(input rsp_t got);
    rsp_t e;
    if (exp_q.size() == 0) begin
      $error("response with no request outstanding");
      errors++;
      return;
    end
    e = exp_q.pop_front();
    n_rsp++;
    if (got.change_valid) n_chg++;
    if (got.reg_ok) n_regok++;
    cmp("handled", 8'(e.handled), 8'(got.handled));
    cmp("read_data", e.read_data, got.read_data);
    cmp("change_valid", 8'(e.change_valid), 8'(got.change_valid));
    cmp("change_offset", e.change_offset, got.change_offset);
    cmp("change_device", e.change_device, got.change_device);
    cmp("change_function", 8'(e.change_function), 8'(got.change_function));
    cmp("reg_ok", 8'(e.reg_ok), 8'(got.reg_ok));
    cmp("reg_slot", 8'(e.reg_slot), 8'(got.reg_slot));
  endtask

  // response side: random stall per response, one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        check_rsp(rsp_if.payload);
        if (long_hold) begin
          stall = LONG_HOLD;
          long_hold = 1'b0;
        end else begin
          stall = no_idle ? 0 : $urandom_range(0, 10);
        end
      end else if (stall > 0) begin
        stall--;
      end
      rsp_if.ready <= (stall == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WD_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WD_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.payload = '0;
    addr_q = '0;
    stat_ok = 1'b0;
    next_dev = '0;
    for (int i = 0; i < NSLOT; i++) begin
      s_vld[i] = 1'b0;
      s_hw[i] = '0;
      s_dev[i] = '0;
      s_fn[i] = '0;
      s_sz[i] = '0;
      s_ntf[i] = 1'b0;
    end
    for (int i = 0; i < NSLOT*CFGB; i++) cfg_set[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    test_dev_wrap();
    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d requests, %0d responses: %0d change events, %0d registrations placed.",
             n_req, n_rsp, n_chg, n_regok);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
